// ----- design/stfms_pkg.sv -----
// Shared types and constants for the sorted-table first-match search block.
// Holds the request/response beat formats and the controller/datapath link.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stfms_pkg;

    localparam int LEN_W   = 11;
    localparam int IDX_W   = 10;
    localparam int WORD_W  = 32;
    localparam int POS_W   = 11;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    localparam logic REG_TABLE_LENGTH = 1'b0;

    typedef struct packed {
        logic                     req_type;
        logic [IDX_W-1:0]         entry_index;
        logic signed [WORD_W-1:0] entry_value;
        logic signed [WORD_W-1:0] search_key;
    } req_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } rsp_t;

    typedef struct packed {
        logic write;
        logic start;
        logic issue;
        logic update;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic range_open;
    } status_t;

endpackage

`default_nettype wire

// ----- design/stfms_ctrl.sv -----
// Sequencer for the sorted-table search: accepts request beats, steps the
// probe loop (read, then compare) and owns the response valid flag.
// Depends on stfms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stfms_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    input  wire logic              req_type,
    output logic                   req_ready,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    input  wire stfms_pkg::status_t status,
    output stfms_pkg::cmd_t        cmd
);
    import stfms_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_type == REQ_SEARCH)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        cmd.write = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                if (status.range_open)
                begin
                    cmd.issue  = 1'b1;
                    state_next = ST_CMP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_CMP:
            begin
                cmd.update = 1'b1;
                state_next = ST_READ;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    cmd.finish     = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/stfms_dp.sv -----
// Datapath for the sorted-table search: table memory, search bounds,
// probe compare, leftmost-hit tracking and the response payload register.
// Depends on stfms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stfms_dp
#(
    parameter int DEPTH = 1024
)
(
    input  wire logic                          clk,
    input  wire stfms_pkg::req_t               req,
    input  wire logic [stfms_pkg::LEN_W-1:0]   table_length,
    input  wire stfms_pkg::cmd_t               cmd,
    output stfms_pkg::status_t                 status,
    output stfms_pkg::rsp_t                    rsp
);
    import stfms_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = (LW > LEN_W) ? LW : LEN_W;

    logic [WORD_W-1:0]        mem [DEPTH];

    logic [LW-1:0]            lo_reg;
    logic [LW-1:0]            hp1_reg;
    logic [LW-1:0]            hit_reg;
    logic [AW-1:0]            mid_reg;
    logic signed [WORD_W-1:0] key_reg;
    logic signed [WORD_W-1:0] rdata_reg;
    rsp_t                     rsp_reg;

    logic [LW-1:0]            eff_len;
    logic [LW:0]              mid_sum;
    logic [AW-1:0]            mid;
    logic [LW-1:0]            mid_inc;
    logic                     index_ok;

    assign eff_len  = (CW'(table_length) > CW'(DEPTH)) ? LW'(DEPTH) : LW'(table_length);
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hp1_reg} - (LW+1)'(1);
    assign mid      = mid_sum[AW:1];
    assign mid_inc  = LW'(mid_reg) + LW'(1);
    assign index_ok = (32'(req.entry_index) < 32'(DEPTH));

    assign status.range_open = (lo_reg < hp1_reg);
    assign rsp               = rsp_reg;

    // single port: writes only while idle, reads only during a search
    always_ff @(posedge clk)
    begin
        if (cmd.write && index_ok)
        begin
            mem[AW'(req.entry_index)] <= req.entry_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            rdata_reg <= mem[mid];
            mid_reg   <= mid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            lo_reg  <= '0;
            hp1_reg <= eff_len;
            hit_reg <= '0;
            key_reg <= req.search_key;
        end
        else if (cmd.update)
        begin
            if (rdata_reg == key_reg)
            begin
                hit_reg <= mid_inc;
                hp1_reg <= LW'(mid_reg);
            end
            else if (rdata_reg < key_reg)
            begin
                lo_reg <= mid_inc;
            end
            else
            begin
                hp1_reg <= LW'(mid_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            rsp_reg.found    <= (hit_reg != '0);
            rsp_reg.position <= POS_W'(hit_reg);
        end
    end

endmodule

`default_nettype wire

// ----- design/sorted_table_first_match_search.sv -----
// Top level of the sorted-table first-match search block.
// Holds the APB length register and joins stfms_ctrl and stfms_dp.
// Depends on stfms_pkg, stfms_ctrl, stfms_dp.
`timescale 1ns / 1ps
`default_nettype none

// Stores DEPTH signed 32-bit entries in a single-port memory (contents
// undefined until written, no clearing after reset) and answers searches with
// the 1-based position of the leftmost entry equal to the key, or found 0 and
// position 0. Software keeps entries 0..table_length-1 sorted ascending and
// sets table_length (APB, byte address 0) while the block is idle; lengths
// above DEPTH search DEPTH entries. A write beat gives no response. A search
// beat runs a binary search in which each probe is one memory read and then
// one compare, with P = floor(log2(len)) + 1 probes at most. One search is in
// flight at a time; a new beat is taken while a finished response still
// waits on rsp_ready.
module sorted_table_first_match_search
#(
    parameter int DEPTH = 1024
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           req_valid,
    output logic                                req_ready,
    input  wire stfms_pkg::req_t                req,
    output logic                                rsp_valid,
    input  wire logic                           rsp_ready,
    output stfms_pkg::rsp_t                     rsp,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [stfms_pkg::APB_AW-1:0]   paddr,
    input  wire logic [stfms_pkg::APB_DW-1:0]   pwdata,
    output logic [stfms_pkg::APB_DW-1:0]        prdata,
    output logic                                pready
);
    import stfms_pkg::*;

    logic [LEN_W-1:0] table_length_reg;
    logic [LEN_W-1:0] table_length_next;
    cmd_t             cmd;
    status_t          status;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_TABLE_LENGTH);

    always_comb
    begin
        table_length_next = table_length_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            table_length_next = pwdata[LEN_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_sel)
        begin
            prdata = APB_DW'(table_length_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_length_reg <= '0;
        end
        else
        begin
            table_length_reg <= table_length_next;
        end
    end

    stfms_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_type  (req.req_type),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .cmd       (cmd)
    );

    stfms_dp
    #(
        .DEPTH (DEPTH)
    )
    u_dp
    (
        .clk          (clk),
        .req          (req),
        .table_length (table_length_reg),
        .cmd          (cmd),
        .status       (status),
        .rsp          (rsp)
    );

endmodule

`default_nettype wire

// ----- verif/sorted_table_first_match_search_test.sv -----
// Testbench for sorted_table_first_match_search: loads sorted tables, sets the
// length over APB and checks every search result against a leftmost-hit binary-search model.
// Depends on stfms_pkg and the design files only.
`timescale 1ns / 1ps

module sorted_table_first_match_search_test;

    import stfms_pkg::*;

    localparam int DEPTH = 1024;
    localparam int REG_SPARE = 1;
    localparam int DRAIN_CYCLES = 32;
    localparam int STALL_LIMIT = 1000;
    localparam int PATH_FILL = 64;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    logic signed [WORD_W-1:0] stored_entries [DEPTH];
    logic [LEN_W-1:0] table_len = '0;
    rsp_t pending_hits [$];
    rsp_t want;
    int mismatches = 0;
    int idle_pct = 0;
    int ready_hold = 0;
    int quiet_cycles = 0;

    sorted_table_first_match_search #(.DEPTH(DEPTH)) i_dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic flag_mismatch(string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic int search_span();
        return (int'(table_len) > DEPTH) ? DEPTH : int'(table_len);
    endfunction

    function automatic rsp_t predict_lookup(logic signed [WORD_W-1:0] key);
        rsp_t outcome;
        int lo;
        int hi;
        int mid;
        int hit;
        lo = 0;
        hi = search_span() - 1;
        hit = 0;
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            if (stored_entries[mid] == key)
            begin
                hit = mid + 1;
                hi = mid - 1;
            end
            else if (stored_entries[mid] < key)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        outcome.found = (hit != 0);
        outcome.position = hit[POS_W-1:0];
        return outcome;
    endfunction

    // response side: random stall bursts
    always @(posedge clk)
    begin
        if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            rsp_ready <= 1'b0;
            ready_hold <= $urandom_range(0, 9);
        end
        else
            rsp_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
        begin
            if (pending_hits.size() == 0)
                flag_mismatch($sformatf("unexpected result found=%0b position=%0d",
                                        rsp.found, rsp.position));
            else
            begin
                want = pending_hits.pop_front();
                if (rsp.found !== want.found)
                    flag_mismatch($sformatf("found %0b, expected %0b", rsp.found, want.found));
                if (rsp.position !== want.position)
                    flag_mismatch($sformatf("position %0d, expected %0d",
                                            rsp.position, want.position));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic issue_request(req_t item);
        int gap;
        gap = (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 10) : 0;
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req <= item;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        if (item.req_type == REQ_WRITE)
            stored_entries[item.entry_index] = item.entry_value;
        else
            pending_hits.push_back(predict_lookup(item.search_key));
    endtask

    task automatic write_entry(int index, logic signed [WORD_W-1:0] value);
        req_t item;
        item.req_type = REQ_WRITE;
        item.entry_index = IDX_W'(index);
        item.entry_value = value;
        item.search_key = $urandom;
        issue_request(item);
    endtask

    task automatic look_up(logic signed [WORD_W-1:0] key);
        req_t item;
        item.req_type = REQ_SEARCH;
        item.entry_index = IDX_W'($urandom);
        item.entry_value = $urandom;
        item.search_key = key;
        issue_request(item);
    endtask

    // drop req_valid, wait until no results are pending, then drain
    task automatic wait_idle();
        req_valid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(logic is_write, int index, logic [APB_DW-1:0] wdata,
                              output logic [APB_DW-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_write;
        paddr <= APB_AW'(4 * index);
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_register(int index, logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] readback;
        wait_idle();
        apb_access(1'b1, index, value, readback);
        if (index == REG_TABLE_LENGTH)
            table_len = value[LEN_W-1:0];
        apb_access(1'b0, REG_TABLE_LENGTH, '0, readback);
        if (readback !== APB_DW'(table_len))
            flag_mismatch($sformatf("table_length reads %0d, expected %0d", readback, table_len));
    endtask

    task automatic load_sorted(int count, int max_step);
        longint level;
        level = ($urandom_range(0, 3) == 0) ? longint'(WORD_MIN) : longint'($signed($urandom));
        for (int i = 0; i < count; i++)
        begin
            if (i != 0 && $urandom_range(0, 2) != 0)
                level += $urandom_range(0, max_step);
            if (level > longint'(WORD_MAX))
                level = WORD_MAX;
            write_entry(i, level[WORD_W-1:0]);
        end
    endtask

    function automatic logic signed [WORD_W-1:0] pick_key(int span);
        logic signed [WORD_W-1:0] near;
        near = (span != 0) ? stored_entries[$urandom_range(0, span - 1)] : $urandom;
        case ($urandom_range(0, 9)) inside
            [0:5]: return near;
            6: return near + 1;
            7: return near - 1;
            8: return ($urandom_range(0, 1) != 0) ? WORD_MAX : WORD_MIN;
            default: return $urandom;
        endcase
    endfunction

    // mostly searches; some rewrites that keep order, some that break it
    task automatic mixed_traffic(int count);
        int span;
        int idx;
        for (int i = 0; i < count; i++)
        begin
            span = search_span();
            if (span != 0 && $urandom_range(0, 6) == 0)
            begin
                idx = $urandom_range(0, span - 1);
                if ($urandom_range(0, 1) != 0)
                    write_entry(idx, stored_entries[(idx == 0) ? 0 : idx - 1]);
                else
                    write_entry(idx, $urandom);
            end
            else
                look_up(pick_key(span));
        end
    endtask

    // keys at or below the top filled entry keep every probe inside the filled slots
    task automatic capped_lookups(int count);
        logic signed [WORD_W-1:0] key;
        for (int i = 0; i < count; i++)
        begin
            key = pick_key(PATH_FILL);
            if (key > stored_entries[PATH_FILL - 1])
                key = stored_entries[PATH_FILL - 1];
            look_up(key);
        end
    endtask

    task automatic test_empty_table();
        idle_pct = 30;
        look_up(0);
        look_up(WORD_MAX);
        look_up(WORD_MIN);
        write_register(REG_SPARE, 32'h0000_0010);
        look_up(0);
    endtask

    task automatic test_directed_lookups();
        logic signed [WORD_W-1:0] seed_values [8];
        seed_values = '{WORD_MIN, WORD_MIN, -5, 0, 0, 0, 7, WORD_MAX};
        idle_pct = 20;
        for (int i = 0; i < 8; i++)
            write_entry(i, seed_values[i]);
        write_register(REG_TABLE_LENGTH, 8);
        look_up(WORD_MIN);
        look_up(-5);
        look_up(0);
        look_up(7);
        look_up(WORD_MAX);
        look_up(-1);
        look_up(1);
        look_up(WORD_MAX - 1);
        look_up(WORD_MIN + 1);
        write_register(REG_TABLE_LENGTH, 1);
        look_up(WORD_MIN);
        look_up(0);
        // break ordering in the middle of the table
        write_register(REG_TABLE_LENGTH, 8);
        write_entry(3, WORD_MAX);
        look_up(0);
        look_up(WORD_MAX);
    endtask

    task automatic test_random_tables();
        int len;
        int step;
        for (int phase = 0; phase < 6; phase++)
        begin
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 20;
                default: idle_pct = 50;
            endcase
            len = (phase % 4 == 3) ? $urandom_range(100, 160) : $urandom_range(1, 40);
            case ($urandom_range(0, 2))
                0: step = 2;
                1: step = 1000;
                default: step = 1 << 24;
            endcase
            load_sorted(len, step);
            write_register(REG_TABLE_LENGTH, APB_DW'($urandom << LEN_W) | APB_DW'(len));
            mixed_traffic(25);
        end
    endtask

    // full and oversized lengths; the left-hand probe path is filled with the maximum
    task automatic test_full_depth();
        idle_pct = 20;
        load_sorted(PATH_FILL, 1 << 23);
        for (int slot = 2 * PATH_FILL - 1; slot < DEPTH; slot = 2 * slot + 1)
            write_entry(slot, WORD_MAX);
        write_register(REG_TABLE_LENGTH, DEPTH);
        capped_lookups(20);
        write_register(REG_TABLE_LENGTH, DEPTH + 1);
        capped_lookups(10);
        write_register(REG_TABLE_LENGTH, 32'hffff_ffff);
        capped_lookups(10);
    endtask

    task automatic test_back_to_back();
        idle_pct = 0;
        load_sorted(33, 3);
        write_register(REG_TABLE_LENGTH, 33);
        mixed_traffic(60);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        rsp_ready <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_directed_lookups();
        test_random_tables();
        test_full_depth();
        test_back_to_back();

        wait_idle();
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
